FILE: sv/tclc_pkg.sv
// Shared types, constants and table helper for the two-channel lux calculator.
`timescale 1ns / 1ps

package tclc_pkg;

   // Default configuration
   localparam int DEF_RATIO_FRAC_BITS   = 16;
   localparam int DEF_POW_TABLE_ENTRIES = 256;
   localparam int DEF_LUX_FRAC_BITS     = 16;

   // Fixed formats
   localparam int COEF_BITS = 24;
   localparam int ROOT_BITS = 12;
   localparam int POW_BITS  = 16;
   localparam int LUX_WIDTH = 27;

   // Queue depths
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 32;

   // Coefficients, unsigned Q.24, rounded to nearest
   localparam logic [COEF_BITS-1:0] K_B0_BASE = COEF_BITS'(((64'd304 << 24) + 64'd5000) / 64'd10000);
   localparam logic [COEF_BITS-1:0] K_B0_POW  = COEF_BITS'(((64'd62 << 24) + 64'd500) / 64'd1000);
   localparam logic [COEF_BITS-1:0] K_B1_BB   = COEF_BITS'(((64'd224 << 24) + 64'd5000) / 64'd10000);
   localparam logic [COEF_BITS-1:0] K_B1_IR   = COEF_BITS'(((64'd31 << 24) + 64'd500) / 64'd1000);
   localparam logic [COEF_BITS-1:0] K_B2_BB   = COEF_BITS'(((64'd128 << 24) + 64'd5000) / 64'd10000);
   localparam logic [COEF_BITS-1:0] K_B2_IR   = COEF_BITS'(((64'd153 << 24) + 64'd5000) / 64'd10000);
   localparam logic [COEF_BITS-1:0] K_B3_BB   = COEF_BITS'(((64'd146 << 24) + 64'd50000) / 64'd100000);
   localparam logic [COEF_BITS-1:0] K_B3_IR   = COEF_BITS'(((64'd112 << 24) + 64'd50000) / 64'd100000);

   // Ratio bands
   typedef enum logic [2:0] {
      BAND_LT_050 = 3'd0,
      BAND_LT_061 = 3'd1,
      BAND_LT_080 = 3'd2,
      BAND_LT_130 = 3'd3,
      BAND_OVER   = 3'd4
   } tclc_band_type;

   typedef struct packed {
      logic [15:0] broadband_count;
      logic [15:0] infrared_count;
   } tclc_req_type;

   typedef struct packed {
      logic [LUX_WIDTH-1:0] lux_value;
      logic [2:0]           ratio_band;
   } tclc_rsp_type;

   // Classified item between front and back
   typedef struct packed {
      tclc_req_type  counts;
      tclc_band_type band;
   } tclc_item_type;

   // t^1.4 in Q.16 for a Q.16 ratio t: t * floor(t^0.4 * 2^12) / 2^12.
   // Only evaluated on constants to build the power table.
   function automatic logic [POW_BITS-1:0] pow_q16(input logic [POW_BITS-1:0] q);
      logic [63:0] target;
      logic [63:0] s;
      logic [63:0] cand;
      logic [63:0] fifth;
      target = (64'(q) * 64'(q)) << (5 * ROOT_BITS - 2 * POW_BITS);
      s      = '0;
      for (int b = ROOT_BITS; b >= 0; b--) begin
         cand  = s | (64'd1 << b);
         fifth = cand * cand * cand * cand * cand;
         if (cand <= (64'd1 << ROOT_BITS) && fifth <= target) begin
            s = cand;
         end
      end
      return POW_BITS'((64'(q) * s) >> ROOT_BITS);
   endfunction

endpackage

FILE: sv/tclc_fifo.sv
// Small register-based queue used between the front, the back and the result port.
`timescale 1ns / 1ps

module tclc_fifo #(
   parameter int WIDTH = $bits(tclc_pkg::tclc_item_type),
   parameter int DEPTH = tclc_pkg::MID_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/tclc_front.sv
// Front end: takes items, picks the ratio band and hands them to the middle queue.
`timescale 1ns / 1ps

module tclc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  tclc_pkg::tclc_req_type req_item,
   output logic                   fwd_push,
   output tclc_pkg::tclc_item_type fwd_item,
   input  logic                   fwd_full
);

   import tclc_pkg::*;

   logic          valid_ff, valid_in;
   tclc_item_type item_ff;
   tclc_band_type band;
   logic          take;
   logic [23:0]   bb_w, ir_w;

   // Exact band choice by cross products
   always_comb begin
      bb_w = 24'(req_item.broadband_count);
      ir_w = 24'(req_item.infrared_count);
      if (bb_w == '0 || (ir_w * 24'd2) < bb_w) begin
         band = BAND_LT_050;
      end else if ((ir_w * 24'd100) < (bb_w * 24'd61)) begin
         band = BAND_LT_061;
      end else if ((ir_w * 24'd5) < (bb_w * 24'd4)) begin
         band = BAND_LT_080;
      end else if ((ir_w * 24'd10) < (bb_w * 24'd13)) begin
         band = BAND_LT_130;
      end else begin
         band = BAND_OVER;
      end
   end

   // One holding register; it drains into the queue while a new item loads
   assign full     = valid_ff && fwd_full;
   assign take     = push && !full;
   assign fwd_push = valid_ff && !fwd_full;
   assign fwd_item = item_ff;
   assign valid_in = take || (valid_ff && fwd_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.counts <= req_item;
         item_ff.band   <= band;
      end
   end

endmodule

FILE: sv/tclc_back.sv
// Back end: fixed-latency pipeline with ratio divider, power table and lux arithmetic.
`timescale 1ns / 1ps

module tclc_back #(
   parameter int RATIO_FRAC_BITS   = tclc_pkg::DEF_RATIO_FRAC_BITS,
   parameter int POW_TABLE_ENTRIES = tclc_pkg::DEF_POW_TABLE_ENTRIES,
   parameter int LUX_FRAC_BITS     = tclc_pkg::DEF_LUX_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  tclc_pkg::tclc_item_type in_item,
   output logic                    out_valid,
   output tclc_pkg::tclc_rsp_type  out_rsp
);

   import tclc_pkg::*;

   // Divider retires two quotient bits per stage
   localparam int QUO_W      = 2 * ((RATIO_FRAC_BITS + 1) / 2);
   localparam int DIV_STAGES = QUO_W / 2;
   localparam int IDX_W      = $clog2(POW_TABLE_ENTRIES);
   localparam int TWO_N      = 2 * POW_TABLE_ENTRIES;
   localparam int IDXF_W     = 14;
   localparam int MUL_W      = RATIO_FRAC_BITS + IDXF_W;
   localparam int LIN_W      = 2 * COEF_BITS - 8;
   localparam int POW_W      = COEF_BITS + POW_BITS;
   localparam int HALF_W     = POW_W / 2;
   localparam int SUM_W      = POW_W + 16;
   localparam int LIN_SH     = COEF_BITS - LUX_FRAC_BITS;
   localparam int POW_SH     = COEF_BITS + POW_BITS - LUX_FRAC_BITS;
   localparam logic [LIN_W:0] LIN_HALF = (LIN_W + 1)'(((LIN_W + 1)'(1) << LIN_SH) >> 1);
   localparam logic [SUM_W:0] POW_HALF = (SUM_W + 1)'(((SUM_W + 1)'(1) << POW_SH) >> 1);
   localparam logic [LUX_WIDTH-1:0] LUX_MAX = '1;
   localparam logic [POW_W-1:0] B0_BASE = {K_B0_BASE, {POW_BITS{1'b0}}};

   // Power table: entry k holds ratio^1.4 at ratio k / (2 * entries)
   logic [POW_BITS-1:0] pow_rom [POW_TABLE_ENTRIES];
   for (genvar k = 0; k < POW_TABLE_ENTRIES; k++) begin : g_rom
      localparam logic [POW_BITS-1:0] QK = POW_BITS'((k << POW_BITS) / TWO_N);
      assign pow_rom[k] = pow_q16(QK);
   end

   // ---------------- divider stages ----------------
   logic          div_valid_ff [DIV_STAGES+1];
   tclc_item_type div_item_ff  [DIV_STAGES+1];
   logic [16:0]   rem_ff       [DIV_STAGES+1];
   logic [QUO_W-1:0] quo_ff    [DIV_STAGES+1];

   // Stage 0 loads the item; remainder starts at the infrared count
   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else begin
         div_valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      div_item_ff[0] <= in_item;
      rem_ff[0]      <= {1'b0, in_item.counts.infrared_count};
      quo_ff[0]      <= '0;
   end

   for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_div
      logic [17:0] sh1, sh2, den;
      logic [16:0] rem1, rem2;
      logic        b1, b2;

      // Two restoring steps
      always_comb begin
         den  = {2'b00, div_item_ff[i-1].counts.broadband_count};
         sh1  = {rem_ff[i-1], 1'b0};
         b1   = (sh1 >= den);
         rem1 = b1 ? 17'(sh1 - den) : sh1[16:0];
         sh2  = {rem1, 1'b0};
         b2   = (sh2 >= den);
         rem2 = b2 ? 17'(sh2 - den) : sh2[16:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[i] <= 1'b0;
         end else begin
            div_valid_ff[i] <= div_valid_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         div_item_ff[i] <= div_item_ff[i-1];
         rem_ff[i]      <= rem2;
         quo_ff[i]      <= {quo_ff[i-1][QUO_W-3:0], b1, b2};
      end
   end

   // ---------------- arithmetic stages 1..7 ----------------
   logic          x_valid_ff [1:7];
   tclc_item_type x_item_ff  [1:7];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 1; j <= 7; j++) begin
            x_valid_ff[j] <= 1'b0;
         end
      end else begin
         x_valid_ff[1] <= div_valid_ff[DIV_STAGES];
         for (int j = 2; j <= 7; j++) begin
            x_valid_ff[j] <= x_valid_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_item_ff[1] <= div_item_ff[DIV_STAGES];
      for (int j = 2; j <= 7; j++) begin
         x_item_ff[j] <= x_item_ff[j-1];
      end
   end

   // Stage 1: table index and linear-band products
   logic [RATIO_FRAC_BITS-1:0] ratio;
   logic [MUL_W-1:0]           idx_prod;
   logic [IDXF_W-1:0]          idx_full;
   logic [IDX_W-1:0]           idx_in, idx_ff;
   logic [COEF_BITS-1:0]       kb, ki;
   logic [LIN_W-1:0]           lin_pos_in, lin_neg_in, lin_pos_ff, lin_neg_ff;
   tclc_item_type              d_item;

   assign d_item = div_item_ff[DIV_STAGES];

   always_comb begin
      ratio    = quo_ff[DIV_STAGES][QUO_W-1 -: RATIO_FRAC_BITS];
      idx_prod = MUL_W'(ratio) * MUL_W'(TWO_N);
      idx_full = idx_prod[MUL_W-1:RATIO_FRAC_BITS];
      if (idx_full > IDXF_W'(POW_TABLE_ENTRIES - 1)) begin
         idx_in = IDX_W'(POW_TABLE_ENTRIES - 1);
      end else begin
         idx_in = idx_full[IDX_W-1:0];
      end
   end

   // Coefficient decoder for the linear bands
   always_comb begin
      unique case (d_item.band)
         BAND_LT_061: begin
            kb = K_B1_BB;
            ki = K_B1_IR;
         end
         BAND_LT_080: begin
            kb = K_B2_BB;
            ki = K_B2_IR;
         end
         BAND_LT_130: begin
            kb = K_B3_BB;
            ki = K_B3_IR;
         end
         default: begin
            kb = '0;
            ki = '0;
         end
      endcase
      lin_pos_in = LIN_W'(d_item.counts.broadband_count) * LIN_W'(kb);
      lin_neg_in = LIN_W'(d_item.counts.infrared_count) * LIN_W'(ki);
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      lin_pos_ff <= lin_pos_in;
      lin_neg_ff <= lin_neg_in;
   end

   // Linear difference, clamped at zero, then carried along
   logic [LIN_W-1:0] lin_ff [2:6];

   always_ff @(posedge clock) begin
      lin_ff[2] <= (lin_pos_ff > lin_neg_ff) ? lin_pos_ff - lin_neg_ff : '0;
      for (int j = 3; j <= 6; j++) begin
         lin_ff[j] <= lin_ff[j-1];
      end
   end

   // Stages 2..6: table read, power term, coefficient, product
   logic [POW_BITS-1:0] pow_ff;
   logic [POW_W-1:0]    kp_ff;
   logic [POW_W-1:0]    coef_ff;
   logic [HALF_W+15:0]  prod_lo_ff, prod_hi_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [15:0]         bb5;

   assign bb5 = x_item_ff[4].counts.broadband_count;

   always_ff @(posedge clock) begin
      pow_ff     <= pow_rom[idx_ff];
      kp_ff      <= POW_W'(K_B0_POW) * POW_W'(pow_ff);
      coef_ff    <= (B0_BASE > kp_ff) ? B0_BASE - kp_ff : '0;
      prod_lo_ff <= (HALF_W + 16)'(bb5) * (HALF_W + 16)'(coef_ff[HALF_W-1:0]);
      prod_hi_ff <= (HALF_W + 16)'(bb5) * (HALF_W + 16)'(coef_ff[POW_W-1:HALF_W]);
      sum_ff     <= (SUM_W'(prod_hi_ff) << HALF_W) + SUM_W'(prod_lo_ff);
   end

   // Stage 7: round half up, saturate, select by band
   logic [SUM_W:0]         pow_round;
   logic [LIN_W:0]         lin_round;
   logic [LUX_WIDTH-1:0]   pow_sat, lin_sat, lux_in;
   tclc_rsp_type           rsp_ff;
   logic                   out_valid_ff;
   tclc_item_type          f_item;

   assign f_item = x_item_ff[6];

   always_comb begin
      pow_round = ((SUM_W + 1)'(sum_ff) + POW_HALF) >> POW_SH;
      lin_round = ((LIN_W + 1)'(lin_ff[6]) + LIN_HALF) >> LIN_SH;
      pow_sat   = (pow_round > (SUM_W + 1)'(LUX_MAX)) ? LUX_MAX : pow_round[LUX_WIDTH-1:0];
      lin_sat   = (lin_round > (LIN_W + 1)'(LUX_MAX)) ? LUX_MAX : lin_round[LUX_WIDTH-1:0];
      unique case (f_item.band)
         BAND_LT_050: lux_in = pow_sat;
         BAND_OVER:   lux_in = '0;
         default:     lux_in = lin_sat;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= x_valid_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.lux_value  <= lux_in;
      rsp_ff.ratio_band <= 3'(f_item.band);
   end

   assign out_valid = out_valid_ff && x_valid_ff[7];
   assign out_rsp   = rsp_ff;

endmodule

FILE: sv/two_channel_lux_calculator.sv
// Path: an accepted item goes through the front holding register, the middle queue, the divider
// stages, the arithmetic stages and the result queue before it reaches the result ports.
// Throughput: one item per cycle sustained; the back pipeline has fixed latency and issues
// only while the 32-entry result queue has a reserved slot for every item in flight.
// Reset: synchronous, clears the queues and pipeline valid bits; ready on the next cycle.
`timescale 1ns / 1ps

module two_channel_lux_calculator #(
   parameter int RATIO_FRAC_BITS   = tclc_pkg::DEF_RATIO_FRAC_BITS,
   parameter int POW_TABLE_ENTRIES = tclc_pkg::DEF_POW_TABLE_ENTRIES,
   parameter int LUX_FRAC_BITS     = tclc_pkg::DEF_LUX_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  tclc_pkg::tclc_req_type req_item,
   output logic                   empty,
   input  logic                   pop,
   output tclc_pkg::tclc_rsp_type rsp_item
);

   import tclc_pkg::*;

   localparam int ITEM_W = $bits(tclc_item_type);
   localparam int RSP_W  = $bits(tclc_rsp_type);
   localparam int RES_W  = $clog2(OUT_DEPTH + 1);

   logic              fwd_push;
   tclc_item_type     fwd_item;
   logic              mid_full;
   logic              mid_empty;
   logic [ITEM_W-1:0] mid_data;
   logic              issue;
   logic              back_valid;
   tclc_rsp_type      back_rsp;
   logic              out_full;
   logic [RSP_W-1:0]  out_data;
   logic              pop_acc;
   logic [RES_W-1:0]  reserved_ff, reserved_in;

   tclc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .fwd_push (fwd_push),
      .fwd_item (fwd_item),
      .fwd_full (mid_full)
   );

   tclc_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fwd_push),
      .push_data (fwd_item),
      .full      (mid_full),
      .pop       (issue),
      .pop_data  (mid_data),
      .empty     (mid_empty)
   );

   // Issue only with a result slot reserved; the back never stalls
   assign pop_acc     = pop && !empty;
   assign issue       = !mid_empty && (reserved_ff < RES_W'(OUT_DEPTH));
   assign reserved_in = reserved_ff + RES_W'(issue) - RES_W'(pop_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
      end else begin
         reserved_ff <= reserved_in;
      end
   end

   tclc_back #(
      .RATIO_FRAC_BITS   (RATIO_FRAC_BITS),
      .POW_TABLE_ENTRIES (POW_TABLE_ENTRIES),
      .LUX_FRAC_BITS     (LUX_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue),
      .in_item   (tclc_item_type'(mid_data)),
      .out_valid (back_valid),
      .out_rsp   (back_rsp)
   );

   tclc_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (back_rsp),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (out_data),
      .empty     (empty)
   );

   assign rsp_item = tclc_rsp_type'(out_data);

   // Result queue full only while every slot is reserved; nothing is pushed then
   logic unused_out_full;
   assign unused_out_full = out_full;

endmodule

FILE: sv/tclc_checker.sv
// Port-level checks for the lux calculator, bound to the top level.
`timescale 1ns / 1ps

module tclc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   push,
   input logic                   full,
   input tclc_pkg::tclc_req_type req_item,
   input logic                   empty,
   input logic                   pop,
   input tclc_pkg::tclc_rsp_type rsp_item
);

   import tclc_pkg::*;

   logic [7:0] pending_ff;
   logic       push_acc;
   logic       pop_acc;
   logic [15:0] unused_bb;

   assign push_acc  = push && !full;
   assign pop_acc   = pop && !empty;
   assign unused_bb = req_item.broadband_count;

   // Items taken but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 8'(push_acc) - 8'(pop_acc);
      end
   end

   a_reset_idle: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("block not idle after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (pending_ff == 8'd0) |-> empty)
      else $error("result shown with no item outstanding");

   a_over_band_dark: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.ratio_band == 3'(BAND_OVER)) |-> (rsp_item.lux_value == '0))
      else $error("lux nonzero in the over-range band");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item)))
      else $error("waiting result changed or vanished");

endmodule

bind two_channel_lux_calculator tclc_checker u_checker (.*);
